FILE: rtl/core/vcrp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcrp_pkg
// Types and codes shared by the video chip CPU register port.
// ----------------------------------------------------------------------------
package vcrp_pkg;

  // operation codes
  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_STATUS = 2'd2;

  // register numbers
  localparam logic [3:0] REG_CTRL      = 4'd0;
  localparam logic [3:0] REG_MASK      = 4'd1;
  localparam logic [3:0] REG_STATUS    = 4'd2;
  localparam logic [3:0] REG_OAM_ADDR  = 4'd3;
  localparam logic [3:0] REG_OAM_DATA  = 4'd4;
  localparam logic [3:0] REG_SCROLL    = 4'd5;
  localparam logic [3:0] REG_ADDR      = 4'd6;
  localparam logic [3:0] REG_DATA      = 4'd7;

  // sprite memory access codes
  localparam logic [1:0] OAM_NONE  = 2'd0;
  localparam logic [1:0] OAM_LOAD  = 2'd1;
  localparam logic [1:0] OAM_WRITE = 2'd2;
  localparam logic [1:0] OAM_READ  = 2'd3;

  // reset values and address constants
  localparam logic [15:0] VRAM_RESET   = 16'h2000;
  localparam logic [2:0]  STATUS_RESET = 3'b101;
  localparam logic [5:0]  PALETTE_PAGE = 6'h3F;
  localparam logic [15:0] STEP_ROW     = 16'd32;
  localparam logic [15:0] STEP_COL     = 16'd1;

  // control and status bit positions
  localparam int CTRL_NMI_BIT  = 7;
  localparam int CTRL_STEP_BIT = 2;
  localparam int STAT_VBL_BIT  = 2;

  typedef struct packed {
    logic [1:0] operation;
    logic [3:0] reg_select;
    logic [7:0] write_data;
    logic [7:0] mem_read_data;
    logic [7:0] oam_read_data;
    logic [2:0] status_in;
  } req_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [15:0] mem_addr;
    logic        mem_read;
    logic        mem_write;
    logic [7:0]  bus_write_data;
    logic [1:0]  oam_op;
    logic        nmi_cancel;
    logic [2:0]  fine_scroll_x;
    logic [14:0] temp_address;
    logic [7:0]  control_out;
    logic [7:0]  mask_out;
  } rsp_t;

endpackage

FILE: rtl/core/vcrp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcrp_if
// Request and response channels of the CPU register port.
// ----------------------------------------------------------------------------
interface vcrp_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [3:0] reg_select;
  logic [7:0] write_data;
  logic [7:0] mem_read_data;
  logic [7:0] oam_read_data;
  logic [2:0] status_in;

  modport source (
    output valid, operation, reg_select, write_data, mem_read_data,
    oam_read_data, status_in,
    input  ready
  );
  modport sink (
    input  valid, operation, reg_select, write_data, mem_read_data,
    oam_read_data, status_in,
    output ready
  );
endinterface

interface vcrp_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic [15:0] mem_addr;
  logic        mem_read;
  logic        mem_write;
  logic [7:0]  bus_write_data;
  logic [1:0]  oam_op;
  logic        nmi_cancel;
  logic [2:0]  fine_scroll_x;
  logic [14:0] temp_address;
  logic [7:0]  control_out;
  logic [7:0]  mask_out;

  modport source (
    output valid, read_data, mem_addr, mem_read, mem_write, bus_write_data,
    oam_op, nmi_cancel, fine_scroll_x, temp_address, control_out, mask_out,
    input  ready
  );
  modport sink (
    input  valid, read_data, mem_addr, mem_read, mem_write, bus_write_data,
    oam_op, nmi_cancel, fine_scroll_x, temp_address, control_out, mask_out,
    output ready
  );
endinterface

FILE: rtl/core/vcrp_regfile.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcrp_regfile
// Register state of the port and the single-pass update for one word.
// ----------------------------------------------------------------------------
module vcrp_regfile (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  vcrp_pkg::req_t item,
  output vcrp_pkg::rsp_t result
);
  import vcrp_pkg::*;

  logic [7:0]  control_reg, control_reg_next;
  logic [7:0]  mask_reg, mask_reg_next;
  logic [2:0]  status_flags, status_flags_next;
  logic [15:0] vram_address, vram_address_next;
  logic [14:0] temp_vram_address, temp_vram_address_next;
  logic [2:0]  fine_x, fine_x_next;
  logic        write_toggle, write_toggle_next;
  logic [7:0]  open_bus, open_bus_next;
  logic [7:0]  read_buffer, read_buffer_next;

  logic [15:0] step;
  logic        palette_hit;
  logic [7:0]  rd;
  logic [7:0]  bwd;
  logic [1:0]  oamop;
  logic        mrd, mwr, cancel;

  // address step and palette window
  assign step        = control_reg[CTRL_STEP_BIT] ? STEP_ROW : STEP_COL;
  assign palette_hit = (vram_address[13:8] == PALETTE_PAGE);

  // next state and response fields for the word in hand
  always_comb begin
    control_reg_next       = control_reg;
    mask_reg_next          = mask_reg;
    status_flags_next      = status_flags;
    vram_address_next      = vram_address;
    temp_vram_address_next = temp_vram_address;
    fine_x_next            = fine_x;
    write_toggle_next      = write_toggle;
    open_bus_next          = open_bus;
    read_buffer_next       = read_buffer;
    rd     = 8'd0;
    bwd    = 8'd0;
    oamop  = OAM_NONE;
    mrd    = 1'b0;
    mwr    = 1'b0;
    cancel = 1'b0;

    case (item.operation)
      OP_READ: begin
        unique case (item.reg_select)
          REG_STATUS: begin
            open_bus_next     = {status_flags, open_bus[4:0]};
            status_flags_next = {1'b0, status_flags[1:0]};
            write_toggle_next = 1'b0;
            rd                = {status_flags, open_bus[4:0]};
          end
          REG_OAM_DATA: begin
            open_bus_next = item.oam_read_data;
            oamop         = OAM_READ;
            rd            = item.oam_read_data;
          end
          REG_DATA: begin
            read_buffer_next  = item.mem_read_data;
            vram_address_next = vram_address + step;
            mrd               = 1'b1;
            rd                = palette_hit ? item.mem_read_data : read_buffer;
            open_bus_next     = rd;
          end
          default: begin
            rd = open_bus;
          end
        endcase
      end
      OP_WRITE: begin
        open_bus_next = item.write_data;
        unique case (item.reg_select)
          REG_CTRL: begin
            control_reg_next              = item.write_data;
            temp_vram_address_next[11:10] = item.write_data[1:0];
            cancel = control_reg[CTRL_NMI_BIT] && !item.write_data[CTRL_NMI_BIT]
                     && status_flags[STAT_VBL_BIT];
          end
          REG_MASK: begin
            mask_reg_next = item.write_data;
          end
          REG_OAM_ADDR: begin
            oamop = OAM_LOAD;
            bwd   = item.write_data;
          end
          REG_OAM_DATA: begin
            oamop = OAM_WRITE;
            bwd   = item.write_data;
          end
          REG_SCROLL: begin
            if (!write_toggle) begin
              fine_x_next                 = item.write_data[2:0];
              temp_vram_address_next[4:0] = item.write_data[7:3];
              write_toggle_next           = 1'b1;
            end else begin
              temp_vram_address_next[14:12] = item.write_data[2:0];
              temp_vram_address_next[9:5]   = item.write_data[7:3];
              write_toggle_next             = 1'b0;
            end
          end
          REG_ADDR: begin
            if (!write_toggle) begin
              temp_vram_address_next[14]   = 1'b0;
              temp_vram_address_next[13:8] = item.write_data[5:0];
              write_toggle_next            = 1'b1;
            end else begin
              temp_vram_address_next[7:0] = item.write_data;
              vram_address_next = {1'b0, temp_vram_address[14:8], item.write_data};
              write_toggle_next = 1'b0;
            end
          end
          REG_DATA: begin
            mwr               = 1'b1;
            bwd               = item.write_data;
            vram_address_next = vram_address + step;
          end
          default: begin
            // no register behind this address
          end
        endcase
      end
      OP_STATUS: begin
        status_flags_next = item.status_in;
      end
      default: begin
        // unused code, no change
      end
    endcase
  end

  // response word
  always_comb begin
    result.read_data      = rd;
    result.mem_addr       = vram_address;
    result.mem_read       = mrd;
    result.mem_write      = mwr;
    result.bus_write_data = bwd;
    result.oam_op         = oamop;
    result.nmi_cancel     = cancel;
    result.fine_scroll_x  = fine_x_next;
    result.temp_address   = temp_vram_address_next;
    result.control_out    = control_reg_next;
    result.mask_out       = mask_reg_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      control_reg       <= 8'd0;
      mask_reg          <= 8'd0;
      status_flags      <= STATUS_RESET;
      vram_address      <= VRAM_RESET;
      temp_vram_address <= 15'd0;
      fine_x            <= 3'd0;
      write_toggle      <= 1'b0;
      open_bus          <= 8'd0;
      read_buffer       <= 8'd0;
    end else if (fire) begin
      control_reg       <= control_reg_next;
      mask_reg          <= mask_reg_next;
      status_flags      <= status_flags_next;
      vram_address      <= vram_address_next;
      temp_vram_address <= temp_vram_address_next;
      fine_x            <= fine_x_next;
      write_toggle      <= write_toggle_next;
      open_bus          <= open_bus_next;
      read_buffer       <= read_buffer_next;
    end
  end

endmodule

FILE: rtl/core/video_chip_cpu_register_port.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_chip_cpu_register_port
// CPU-facing register port of a tile video chip: one register access or
// status update per request word, one response word each.
// ----------------------------------------------------------------------------
//  channel | dir | word
//  req     | in  | operation, register, write byte, memory/sprite read bytes,
//          |     | status flags
//  rsp     | out | read byte, vram address, memory and sprite access strobes,
//          |     | scroll/address/control/mask views
//
//  One word per cycle while rsp does not stall; a word passes through the input
//  register, then the register update and the response register.
//  rst is synchronous, active high; it clears both stages and the registers.
//  A stall on rsp holds the response and backs up into the input register;
//  req.ready drops only when both stages are full and rsp is not taken.
// ----------------------------------------------------------------------------
module video_chip_cpu_register_port (
  input  logic         clk,
  input  logic         rst,
  vcrp_req_if.sink     req,
  vcrp_rsp_if.source   rsp
);
  import vcrp_pkg::*;

  logic  in_valid;
  req_t  in_item;
  logic  out_valid;
  rsp_t  out_item;
  rsp_t  result;
  logic  advance;
  logic  take;

  // stage handshakes
  assign advance   = in_valid && (!out_valid || rsp.ready);
  assign take      = req.valid && req.ready;
  assign req.ready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_item <= '{operation:     req.operation,
                   reg_select:    req.reg_select,
                   write_data:    req.write_data,
                   mem_read_data: req.mem_read_data,
                   oam_read_data: req.oam_read_data,
                   status_in:     req.status_in};
    end
  end

  // register state and update logic
  vcrp_regfile u_regfile (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (in_item),
    .result (result)
  );

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

  // response channel
  assign rsp.valid          = out_valid;
  assign rsp.read_data      = out_item.read_data;
  assign rsp.mem_addr       = out_item.mem_addr;
  assign rsp.mem_read       = out_item.mem_read;
  assign rsp.mem_write      = out_item.mem_write;
  assign rsp.bus_write_data = out_item.bus_write_data;
  assign rsp.oam_op         = out_item.oam_op;
  assign rsp.nmi_cancel     = out_item.nmi_cancel;
  assign rsp.fine_scroll_x  = out_item.fine_scroll_x;
  assign rsp.temp_address   = out_item.temp_address;
  assign rsp.control_out    = out_item.control_out;
  assign rsp.mask_out       = out_item.mask_out;

endmodule

FILE: rtl/core/vcrp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcrp_checker
// Port-level checks of the CPU register port, bound to the top level.
// ----------------------------------------------------------------------------
module vcrp_checker (
  input logic       clk,
  input logic       rst,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic       rsp_mem_read,
  input logic       rsp_mem_write,
  input logic [1:0] rsp_oam_op,
  input logic       rsp_nmi_cancel,
  input logic [7:0] rsp_control_out
);
  import vcrp_pkg::*;

  // response valid held while stalled
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response word dropped under stall");

  // nothing comes out of reset
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid right after reset");

  // a word touches at most one memory
  a_one_access: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_mem_read || rsp_mem_write) |->
      !(rsp_mem_read && rsp_mem_write) && rsp_oam_op == OAM_NONE)
    else $error("conflicting memory accesses in one word");

  // a cancel only comes with nmi enable now clear
  a_cancel_ctrl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_nmi_cancel |-> !rsp_control_out[CTRL_NMI_BIT]
      && !rsp_mem_read && !rsp_mem_write)
    else $error("nmi cancel with nmi enable still set");

endmodule

bind video_chip_cpu_register_port vcrp_checker u_vcrp_checker (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_mem_read    (rsp.mem_read),
  .rsp_mem_write   (rsp.mem_write),
  .rsp_oam_op      (rsp.oam_op),
  .rsp_nmi_cancel  (rsp.nmi_cancel),
  .rsp_control_out (rsp.control_out)
);

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the video chip CPU register port. A directed table
// of register accesses runs first, then random access sequences with bursty
// request traffic and a stalling response side. Every accepted request word
// is run through a behavioral copy of the register file, and each response
// word is compared field by field with the oldest predicted word.
// ----------------------------------------------------------------------------
module testbench;
  import vcrp_pkg::*;

  // operation code that the port must ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int HOLD_CYCLES     = 100;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 10;
  localparam int REPORT_LIMIT    = 40;
  // enough step-32 data accesses from 0x7fff to carry the address past 0xffff
  localparam int SWEEP_STEPS     = 1030;

  typedef struct {
    req_t word;
    bit   typed;
    rsp_t want;
  } table_row_t;

  logic clk;
  logic rst;

  vcrp_req_if req_ch ();
  vcrp_rsp_if rsp_ch ();

  video_chip_cpu_register_port dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // register file copy used for prediction
  logic [7:0]  port_ctrl;
  logic [7:0]  port_mask;
  logic [2:0]  port_flags;
  logic [15:0] cur_vaddr;
  logic [14:0] tmp_vaddr;
  logic [2:0]  scroll_fine_x;
  logic        second_write;
  logic [7:0]  bus_latch;
  logic [7:0]  read_latch;

  rsp_t       expected_words[$];
  table_row_t directed_rows[$];

  // handshake side channel from the driver to the monitor
  bit   typed_pending;
  rsp_t typed_rsp;

  // traffic shaping
  bit sender_bursty;
  int burst_left;
  bit sink_steady;
  int hold_requests;

  int error_count;
  int words_sent;
  int responses_seen;
  int idle_cycles;

  // clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) $display("ERROR: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_error($sformatf("response %0d %s: got 0x%0h, expected 0x%0h",
                             responses_seen, name, got, want));
  endtask

  // one register access applied to the register file copy
  function automatic rsp_t predict_access(input req_t w);
    rsp_t        r;
    logic [15:0] step;
    logic [7:0]  val;
    logic        nmi_was;
    r = '0;
    r.mem_addr = cur_vaddr;
    step = port_ctrl[CTRL_STEP_BIT] ? STEP_ROW : STEP_COL;
    case (w.operation)
      OP_READ: begin
        case (w.reg_select)
          REG_STATUS: begin
            bus_latch = {port_flags, bus_latch[4:0]};
            port_flags[STAT_VBL_BIT] = 1'b0;
            second_write = 1'b0;
            r.read_data = bus_latch;
          end
          REG_OAM_DATA: begin
            bus_latch = w.oam_read_data;
            r.oam_op = OAM_READ;
            r.read_data = bus_latch;
          end
          REG_DATA: begin
            // buffered read, except that palette data comes straight through
            val = read_latch;
            read_latch = w.mem_read_data;
            if (cur_vaddr[13:8] == PALETTE_PAGE) val = read_latch;
            cur_vaddr = cur_vaddr + step;
            bus_latch = val;
            r.mem_read = 1'b1;
            r.read_data = val;
          end
          default: r.read_data = bus_latch;
        endcase
      end
      OP_WRITE: begin
        bus_latch = w.write_data;
        case (w.reg_select)
          REG_CTRL: begin
            nmi_was = port_ctrl[CTRL_NMI_BIT];
            port_ctrl = w.write_data;
            tmp_vaddr[11:10] = w.write_data[1:0];
            if (nmi_was && !w.write_data[CTRL_NMI_BIT] && port_flags[STAT_VBL_BIT])
              r.nmi_cancel = 1'b1;
          end
          REG_MASK: port_mask = w.write_data;
          REG_OAM_ADDR: begin
            r.oam_op = OAM_LOAD;
            r.bus_write_data = w.write_data;
          end
          REG_OAM_DATA: begin
            r.oam_op = OAM_WRITE;
            r.bus_write_data = w.write_data;
          end
          REG_SCROLL: begin
            if (!second_write) begin
              scroll_fine_x = w.write_data[2:0];
              tmp_vaddr[4:0] = w.write_data[7:3];
            end else begin
              tmp_vaddr[14:12] = w.write_data[2:0];
              tmp_vaddr[9:5] = w.write_data[7:3];
            end
            second_write = !second_write;
          end
          REG_ADDR: begin
            if (!second_write) begin
              tmp_vaddr[14] = 1'b0;
              tmp_vaddr[13:8] = w.write_data[5:0];
            end else begin
              tmp_vaddr[7:0] = w.write_data;
              cur_vaddr = {1'b0, tmp_vaddr};
            end
            second_write = !second_write;
          end
          REG_DATA: begin
            r.mem_write = 1'b1;
            r.bus_write_data = w.write_data;
            cur_vaddr = cur_vaddr + step;
          end
          default: ;
        endcase
      end
      OP_STATUS: port_flags = w.status_in;
      default: ;
    endcase
    r.fine_scroll_x = scroll_fine_x;
    r.temp_address = tmp_vaddr;
    r.control_out = port_ctrl;
    r.mask_out = port_mask;
    return r;
  endfunction

  // cpu access with random noise in the side fields
  function automatic req_t cpu_word(input logic [1:0] op, input logic [3:0] sel,
                                    input logic [7:0] data);
    req_t w;
    w.operation = op;
    w.reg_select = sel;
    w.write_data = data;
    w.mem_read_data = 8'($urandom);
    w.oam_read_data = 8'($urandom);
    w.status_in = 3'($urandom);
    return w;
  endfunction

  // response expected right after reset, with only the read byte varying
  function automatic rsp_t reset_view(input logic [7:0] rd);
    rsp_t r;
    r = '0;
    r.read_data = rd;
    r.mem_addr = VRAM_RESET;
    return r;
  endfunction

  task automatic add_row(input req_t w, input bit typed, input rsp_t want);
    table_row_t row;
    row.word = w;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  // offer one word, wait for acceptance, then maybe open a gap
  task automatic send_word(input req_t w, input bit typed, input rsp_t want);
    int gap;
    @(negedge clk);
    req_ch.valid = 1'b1;
    req_ch.operation = w.operation;
    req_ch.reg_select = w.reg_select;
    req_ch.write_data = w.write_data;
    req_ch.mem_read_data = w.mem_read_data;
    req_ch.oam_read_data = w.oam_read_data;
    req_ch.status_in = w.status_in;
    typed_pending = typed;
    typed_rsp = want;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    words_sent++;
    if (sender_bursty) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 8);
        burst_left = $urandom_range(1, 16);
        @(negedge clk);
        req_ch.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_cpu(input logic [1:0] op, input logic [3:0] sel,
                          input logic [7:0] data);
    send_word(cpu_word(op, sel, data), 1'b0, '0);
  endtask

  // sender stops until every predicted word has come back
  task automatic wait_drained();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  // one random access sequence, mostly well formed
  task automatic register_sequence();
    req_t       w;
    logic [1:0] op;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        // address setup followed by a run of data accesses
        if ($urandom_range(0, 3) != 0) send_cpu(OP_READ, REG_STATUS, 8'($urandom));
        send_cpu(OP_WRITE, REG_ADDR,
                 ($urandom_range(0, 3) == 0) ? (8'($urandom) | 8'h3F) : 8'($urandom));
        send_cpu(OP_WRITE, REG_ADDR, 8'($urandom));
        repeat ($urandom_range(1, 8))
          send_cpu($urandom_range(0, 1) ? OP_WRITE : OP_READ, REG_DATA, 8'($urandom));
      end
      3: begin
        if ($urandom_range(0, 3) != 0) send_cpu(OP_READ, REG_STATUS, 8'($urandom));
        send_cpu(OP_WRITE, REG_SCROLL, 8'($urandom));
        send_cpu(OP_WRITE, REG_SCROLL, 8'($urandom));
      end
      4: begin
        send_cpu(OP_WRITE, REG_CTRL, 8'($urandom));
        send_cpu(OP_WRITE, REG_MASK, 8'($urandom));
      end
      5: begin
        // nmi enable dropped with vblank usually set
        w = cpu_word(OP_STATUS, 4'($urandom), 8'($urandom));
        w.status_in[STAT_VBL_BIT] = ($urandom_range(0, 3) != 0);
        send_word(w, 1'b0, '0);
        send_cpu(OP_WRITE, REG_CTRL, 8'($urandom) | 8'h80);
        send_cpu(OP_WRITE, REG_CTRL, 8'($urandom) & 8'h7F);
      end
      6: begin
        send_cpu(OP_WRITE, REG_OAM_ADDR, 8'($urandom));
        repeat ($urandom_range(1, 4))
          send_cpu($urandom_range(0, 1) ? OP_WRITE : OP_READ, REG_OAM_DATA,
                   8'($urandom));
      end
      7: begin
        send_cpu(OP_STATUS, 4'($urandom), 8'($urandom));
        send_cpu(OP_READ, REG_STATUS, 8'($urandom));
      end
      default: begin
        case ($urandom_range(0, 9))
          0:       op = OP_UNUSED;
          1, 2:    op = OP_STATUS;
          3, 4, 5: op = OP_READ;
          default: op = OP_WRITE;
        endcase
        send_cpu(op, 4'($urandom), 8'($urandom));
      end
    endcase
  endtask

  // response side: stall pattern, quiet stretches and long hold-offs
  initial begin : sink_side
    logic [15:0] stall_bits;
    int          hold_left;
    int          holds_seen;
    int          cycle_no;
    rsp_ch.ready = 1'b0;
    stall_bits = 16'hFFFF;
    hold_left = 0;
    holds_seen = 0;
    cycle_no = 0;
    forever begin
      @(negedge clk);
      cycle_no++;
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (cycle_no % 64 == 0)
        stall_bits = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      stall_bits = {stall_bits[0], stall_bits[15:1]};
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready = 1'b0;
      end else begin
        rsp_ch.ready = sink_steady ? 1'b1 : stall_bits[0];
      end
    end
  end

  // monitor: check responses, predict accepted requests, watchdog
  always @(posedge clk) begin : monitor
    req_t w;
    rsp_t want;
    rsp_t guess;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_words.size() == 0) begin
          report_error($sformatf("response %0d arrived with nothing expected",
                                 responses_seen));
        end else begin
          want = expected_words.pop_front();
          check_field("read_data", 16'(rsp_ch.read_data), 16'(want.read_data));
          check_field("mem_addr", rsp_ch.mem_addr, want.mem_addr);
          check_field("mem_read", 16'(rsp_ch.mem_read), 16'(want.mem_read));
          check_field("mem_write", 16'(rsp_ch.mem_write), 16'(want.mem_write));
          check_field("bus_write_data", 16'(rsp_ch.bus_write_data),
                      16'(want.bus_write_data));
          check_field("oam_op", 16'(rsp_ch.oam_op), 16'(want.oam_op));
          check_field("nmi_cancel", 16'(rsp_ch.nmi_cancel), 16'(want.nmi_cancel));
          check_field("fine_scroll_x", 16'(rsp_ch.fine_scroll_x),
                      16'(want.fine_scroll_x));
          check_field("temp_address", 16'(rsp_ch.temp_address),
                      16'(want.temp_address));
          check_field("control_out", 16'(rsp_ch.control_out), 16'(want.control_out));
          check_field("mask_out", 16'(rsp_ch.mask_out), 16'(want.mask_out));
        end
        responses_seen++;
      end
      if (req_ch.valid && req_ch.ready) begin
        w.operation = req_ch.operation;
        w.reg_select = req_ch.reg_select;
        w.write_data = req_ch.write_data;
        w.mem_read_data = req_ch.mem_read_data;
        w.oam_read_data = req_ch.oam_read_data;
        w.status_in = req_ch.status_in;
        guess = predict_access(w);
        expected_words.push_back(typed_pending ? typed_rsp : guess);
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("ERROR: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("video_chip_cpu_register_port regression: fail");
        $finish;
      end
    end
  end

  // stimulus
  initial begin : stimulus
    req_t w;
    int   phase_end;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.operation = OP_READ;
    req_ch.reg_select = REG_CTRL;
    req_ch.write_data = '0;
    req_ch.mem_read_data = '0;
    req_ch.oam_read_data = '0;
    req_ch.status_in = '0;
    typed_pending = 1'b0;
    typed_rsp = '0;
    sender_bursty = 1'b0;
    burst_left = 0;
    sink_steady = 1'b1;
    hold_requests = 0;
    error_count = 0;
    words_sent = 0;
    responses_seen = 0;
    idle_cycles = 0;

    port_ctrl = '0;
    port_mask = '0;
    port_flags = STATUS_RESET;
    cur_vaddr = VRAM_RESET;
    tmp_vaddr = '0;
    scroll_fine_x = '0;
    second_write = 1'b0;
    bus_latch = '0;
    read_latch = '0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table: open bus after reset, extremes, special registers
    add_row(cpu_word(OP_READ, REG_STATUS, 8'h00), 1'b1, reset_view(8'hA0));
    add_row(cpu_word(OP_READ, REG_STATUS, 8'h00), 1'b1, reset_view(8'h20));
    add_row(cpu_word(OP_READ, REG_CTRL, 8'h00), 1'b1, reset_view(8'h20));
    add_row(cpu_word(OP_WRITE, 4'd15, 8'hFF), 1'b1, reset_view(8'h00));
    add_row(cpu_word(OP_READ, 4'd8, 8'h00), 1'b1, reset_view(8'hFF));
    // write to the read-only status register only loads the open bus
    add_row(cpu_word(OP_WRITE, REG_STATUS, 8'h00), 1'b0, '0);
    w = cpu_word(OP_STATUS, REG_CTRL, 8'h00);
    w.status_in = 3'b111;
    add_row(w, 1'b0, '0);
    add_row(cpu_word(OP_WRITE, REG_CTRL, 8'hFF), 1'b0, '0);
    // nmi enable cleared inside vblank
    add_row(cpu_word(OP_WRITE, REG_CTRL, 8'h00), 1'b0, '0);
    add_row(cpu_word(OP_WRITE, REG_MASK, 8'hFF), 1'b0, '0);
    add_row(cpu_word(OP_WRITE, REG_SCROLL, 8'hFF), 1'b0, '0);
    add_row(cpu_word(OP_WRITE, REG_SCROLL, 8'hFF), 1'b0, '0);
    add_row(cpu_word(OP_WRITE, REG_ADDR, 8'hFF), 1'b0, '0);
    add_row(cpu_word(OP_WRITE, REG_ADDR, 8'h00), 1'b0, '0);
    // palette read bypasses the buffer
    w = cpu_word(OP_READ, REG_DATA, 8'h00);
    w.mem_read_data = 8'hFF;
    add_row(w, 1'b0, '0);
    add_row(cpu_word(OP_WRITE, REG_CTRL, 8'h04), 1'b0, '0);
    add_row(cpu_word(OP_WRITE, REG_DATA, 8'h00), 1'b0, '0);
    add_row(cpu_word(OP_WRITE, REG_ADDR, 8'h00), 1'b0, '0);
    add_row(cpu_word(OP_WRITE, REG_ADDR, 8'h00), 1'b0, '0);
    // ordinary read returns the old buffer
    w = cpu_word(OP_READ, REG_DATA, 8'h00);
    w.mem_read_data = 8'h00;
    add_row(w, 1'b0, '0);
    add_row(cpu_word(OP_WRITE, REG_OAM_ADDR, 8'hFF), 1'b0, '0);
    add_row(cpu_word(OP_WRITE, REG_OAM_DATA, 8'h00), 1'b0, '0);
    w = cpu_word(OP_READ, REG_OAM_DATA, 8'h00);
    w.oam_read_data = 8'hFF;
    add_row(w, 1'b0, '0);
    // status read after the first scroll write resets the toggle
    add_row(cpu_word(OP_WRITE, REG_SCROLL, 8'h00), 1'b0, '0);
    add_row(cpu_word(OP_READ, REG_STATUS, 8'h00), 1'b0, '0);
    add_row(cpu_word(OP_UNUSED, REG_DATA, 8'hFF), 1'b0, '0);

    foreach (directed_rows[i])
      send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
    wait_drained();

    // steady traffic on both sides
    phase_end = words_sent + 60;
    while (words_sent < phase_end) register_sequence();
    wait_drained();

    // long response hold-off while requests keep coming, then bursty traffic
    sink_steady = 1'b0;
    hold_requests++;
    repeat (24) register_sequence();
    sender_bursty = 1'b1;
    phase_end = words_sent + 60;
    while (words_sent < phase_end) register_sequence();
    wait_drained();

    // address sweep with step 32 across the 16-bit wrap, starting at 0x7fff
    send_cpu(OP_WRITE, REG_CTRL, 8'($urandom) | 8'h04);
    send_cpu(OP_READ, REG_STATUS, 8'($urandom));
    send_cpu(OP_WRITE, REG_ADDR, 8'hFF);
    // second scroll write sets the top address bits
    send_cpu(OP_WRITE, REG_SCROLL, 8'hFF);
    send_cpu(OP_WRITE, REG_SCROLL, 8'($urandom));
    send_cpu(OP_WRITE, REG_ADDR, 8'hFF);
    repeat (SWEEP_STEPS) begin
      if ($urandom_range(0, 15) == 0) send_cpu(OP_READ, 4'($urandom), 8'($urandom));
      send_cpu($urandom_range(0, 1) ? OP_WRITE : OP_READ, REG_DATA, 8'($urandom));
    end
    wait_drained();

    // back-to-back requests against a stalling response side
    sender_bursty = 1'b0;
    phase_end = words_sent + 60;
    while (words_sent < phase_end) register_sequence();

    // bursty requests against a steady response side
    sender_bursty = 1'b1;
    sink_steady = 1'b1;
    phase_end = words_sent + 60;
    while (words_sent < phase_end) register_sequence();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_words.size() != 0)
      report_error($sformatf("%0d responses never arrived", expected_words.size()));
    if (error_count == 0) begin
      $display("video_chip_cpu_register_port regression: pass");
    end else begin
      $display("video_chip_cpu_register_port regression: fail");
    end
    $finish;
  end

endmodule
